@@ sv/irc_message_line_parser_top_assert.svh @@
// Assertion macros for the IRC message line parser.
// Needs a clock named clk and an active-low reset named arst_n in the including scope.
`ifndef IRC_MESSAGE_LINE_PARSER_TOP_ASSERT_SVH
`define IRC_MESSAGE_LINE_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IMLP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define IMLP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/imlp_pkg.sv @@
// Shared types and constants for the IRC message line parser.
// No dependencies; imported by irc_message_line_parser_top.
`default_nettype none

package imlp_pkg;

	localparam int MAX_ARGS_DEF = 15;
	localparam int LINE_MAX_DEF = 512;

	localparam int BYTE_W  = 8;
	localparam int POS_W   = 9;
	localparam int IDX_W   = 4;
	localparam int CODE_W  = 4;
	localparam int CNT_W   = 4;
	localparam int NUM_W   = 18;
	localparam int MAG_W   = 17;
	localparam int LEN_W   = 4;
	localparam int TDATA_W = 64;
	localparam int TUSER_W = 3;

	localparam int KW_COUNT = 10;

	localparam logic [MAG_W-1:0] NUM_CAP = MAG_W'(99999);
	localparam logic [POS_W-1:0] POS_MAX = '1;
	localparam logic [LEN_W-1:0] LEN_MAX = '1;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_BANG  = 8'h21;
	localparam logic [BYTE_W-1:0] CH_AT    = 8'h40;
	localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

	localparam logic [CODE_W-1:0] CODE_NONE    = 4'd0;
	localparam logic [CODE_W-1:0] CODE_NUMERIC = 4'd11;

	typedef enum logic [2:0] {
		ROLE_DELIM   = 3'd0,
		ROLE_PREFIX  = 3'd1,
		ROLE_COMMAND = 3'd2,
		ROLE_ARG     = 3'd3,
		ROLE_TRAIL   = 3'd4,
		ROLE_DISCARD = 3'd5
	} role_t;

	// Keyword text, first character at index 0; order gives codes 1 to 10.
	localparam logic [BYTE_W-1:0] KW_TEXT [KW_COUNT][8] = '{
		'{"P", "I", "N", "G", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"J", "O", "I", "N", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"P", "A", "R", "T", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"P", "R", "I", "V", "M", "S", "G", CH_NUL},
		'{"N", "O", "T", "I", "C", "E", CH_NUL, CH_NUL},
		'{"K", "I", "C", "K", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"M", "O", "D", "E", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"I", "N", "V", "I", "T", "E", CH_NUL, CH_NUL},
		'{"N", "I", "C", "K", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"Q", "U", "I", "T", CH_NUL, CH_NUL, CH_NUL, CH_NUL}
	};

	localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{
		4'd4, 4'd4, 4'd4, 4'd7, 4'd6, 4'd4, 4'd4, 4'd6, 4'd4, 4'd4
	};

endpackage

`default_nettype wire

@@ sv/irc_message_line_parser_top.sv @@
// The result word for an accepted byte is registered and offered on the master side in the next cycle.
// Throughput: one byte per cycle; a new byte enters in the cycle the waiting result
// is taken, so the path stalls only when m_tready is low and the register is full.
// The summary fields are formed from the parse state after the last byte is applied.
// Reset (arst_n low) returns the parser to line start and empties the output register.
// IRC message line parser: role tagging per byte and a line summary on the last byte.
// Depends on imlp_pkg and irc_message_line_parser_top_assert.svh.
`default_nettype none

`include "irc_message_line_parser_top_assert.svh"

module irc_message_line_parser_top
	import imlp_pkg::*;
#(
	parameter int MAX_ARGS = MAX_ARGS_DEF,
	parameter int LINE_MAX = LINE_MAX_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [BYTE_W-1:0]  s_tdata,   // [7:0] line_byte
	input  wire logic               s_tlast,   // line_end
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [TDATA_W-1:0]      m_tdata,   // [3:0] arg_index, [12:4] position,
	                                           // [13] parse_error, [17:14] command_code,
	                                           // [35:18] numeric_value, [39:36] arg_count,
	                                           // [40] has_trailing, [41] sender_is_user,
	                                           // [50:42] nick_end, [59:51] user_end, rest 0
	output logic [TUSER_W-1:0]      m_tuser,   // [2:0] byte_role
	output logic                    m_tlast    // line_done
);

	localparam int PFW  = $clog2(MAX_ARGS + 1);
	localparam int OFFW = $clog2(LINE_MAX + 1);

	typedef enum logic [2:0] {
		PH_START, PH_PREFIX, PH_COMMAND, PH_PSTART, PH_PARAM, PH_TRAIL, PH_DISCARD
	} phase_t;

	typedef enum logic [1:0] {
		NS_SKIP, NS_DIGITS, NS_DONE
	} num_stage_t;

	// parse state
	phase_t                phase_q, phase_n;
	logic [OFFW-1:0]       off_q, off_n;
	logic [KW_COUNT-1:0]   hits_q, hits_n;
	logic [LEN_W-1:0]      cmdlen_q, cmdlen_n;
	logic [MAG_W-1:0]      mag_q, mag_n;
	logic                  neg_q, neg_n;
	num_stage_t            nstage_q, nstage_n;
	logic [PFW-1:0]        pf_q, pf_n;
	logic                  trail_q, trail_n;
	logic                  bang_seen_q, bang_seen_n;
	logic                  at_seen_q, at_seen_n;
	logic [POS_W-1:0]      bang_off_q, bang_off_n;
	logic [POS_W-1:0]      at_off_q, at_off_n;

	// result register
	logic                  out_valid_q;
	role_t                 role_q;
	logic [IDX_W-1:0]      idx_q;
	logic [POS_W-1:0]      pos_q;
	logic                  done_q;
	logic                  err_q;
	logic [CODE_W-1:0]     code_q;
	logic [NUM_W-1:0]      num_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  has_trail_q;
	logic                  user_q;
	logic [POS_W-1:0]      nick_end_q;
	logic [POS_W-1:0]      user_end_q;

	// per-byte logic
	logic                  accept;
	logic [BYTE_W-1:0]     b;
	logic                  in_range;
	logic                  cmd_step;
	role_t                 role_w;
	logic [IDX_W-1:0]      idx_w;
	logic [12:0]           off_ext;
	logic [POS_W-1:0]      pos_w;
	logic                  is_digit;
	logic [3:0]            digit;
	logic [20:0]           mag_prod;
	logic [PFW-1:0]        pf_m1;

	// summary logic
	logic                  err_w;
	logic [CODE_W-1:0]     code_w;
	logic [NUM_W-1:0]      num_w;
	logic [7:0]            cnt_ext;
	logic [CNT_W-1:0]      cnt_w;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = !out_valid_q || m_tready;
	assign b        = s_tdata;
	assign in_range = off_q < OFFW'(LINE_MAX);
	assign off_ext  = 13'(off_q);
	assign pos_w    = (off_ext > 13'(POS_MAX)) ? POS_MAX : off_ext[POS_W-1:0];
	assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
	assign digit    = b[3:0];
	assign mag_prod = 21'(mag_q) * 21'd10 + 21'(digit);
	assign pf_m1    = pf_q - PFW'(1);

	always_comb begin
		phase_n     = phase_q;
		off_n       = off_q;
		hits_n      = hits_q;
		cmdlen_n    = cmdlen_q;
		mag_n       = mag_q;
		neg_n       = neg_q;
		nstage_n    = nstage_q;
		pf_n        = pf_q;
		trail_n     = trail_q;
		bang_seen_n = bang_seen_q;
		at_seen_n   = at_seen_q;
		bang_off_n  = bang_off_q;
		at_off_n    = at_off_q;
		role_w      = ROLE_DISCARD;
		idx_w       = '0;
		cmd_step    = 1'b0;

		if (in_range) begin
			off_n = off_q + OFFW'(1);
			case (phase_q)
				PH_START, PH_COMMAND: begin
					if (phase_q == PH_START && b == CH_COLON) begin
						role_w  = ROLE_DELIM;
						phase_n = PH_PREFIX;
					end else if (b == CH_SPACE) begin
						role_w  = ROLE_DELIM;
						phase_n = PH_PSTART;
					end else begin
						role_w   = ROLE_COMMAND;
						phase_n  = PH_COMMAND;
						cmd_step = 1'b1;
					end
				end
				PH_PREFIX: begin
					if (b == CH_SPACE) begin
						role_w  = ROLE_DELIM;
						phase_n = PH_COMMAND;
					end else begin
						role_w = ROLE_PREFIX;
						if (b == CH_BANG && !bang_seen_q) begin
							bang_seen_n = 1'b1;
							bang_off_n  = pos_w;
						end else if (b == CH_AT && bang_seen_q && !at_seen_q) begin
							at_seen_n = 1'b1;
							at_off_n  = pos_w;
						end
					end
				end
				PH_PSTART: begin
					if (b == CH_COLON) begin
						role_w  = ROLE_DELIM;
						trail_n = 1'b1;
						phase_n = PH_TRAIL;
					end else begin
						pf_n = pf_q + PFW'(1);
						if (b == CH_SPACE) begin
							role_w  = ROLE_DELIM;
							phase_n = (pf_n < PFW'(MAX_ARGS)) ? PH_PSTART : PH_DISCARD;
						end else begin
							role_w  = ROLE_ARG;
							idx_w   = IDX_W'(pf_q);
							phase_n = PH_PARAM;
						end
					end
				end
				PH_PARAM: begin
					if (b == CH_SPACE) begin
						role_w  = ROLE_DELIM;
						phase_n = (pf_q < PFW'(MAX_ARGS)) ? PH_PSTART : PH_DISCARD;
					end else begin
						role_w = ROLE_ARG;
						idx_w  = IDX_W'(pf_m1);
					end
				end
				PH_TRAIL: begin
					role_w = ROLE_TRAIL;
				end
				default: begin
					role_w = ROLE_DISCARD;
				end
			endcase
		end

		// command token: keyword narrowing and atoi
		if (cmd_step) begin
			for (int k = 0; k < KW_COUNT; k++) begin
				if (cmdlen_q >= KW_LEN[k] || KW_TEXT[k][cmdlen_q[2:0]] != b) begin
					hits_n[k] = 1'b0;
				end
			end
			if (cmdlen_q != LEN_MAX) begin
				cmdlen_n = cmdlen_q + LEN_W'(1);
			end
			case (nstage_q)
				NS_SKIP: begin
					if (b inside {CH_SPACE, [CH_TAB:CH_CR]}) begin
						nstage_n = NS_SKIP;
					end else if (b == CH_PLUS) begin
						nstage_n = NS_DIGITS;
					end else if (b == CH_MINUS) begin
						neg_n    = 1'b1;
						nstage_n = NS_DIGITS;
					end else if (is_digit) begin
						mag_n    = MAG_W'(digit);
						nstage_n = NS_DIGITS;
					end else begin
						nstage_n = NS_DONE;
					end
				end
				NS_DIGITS: begin
					if (is_digit) begin
						mag_n = (mag_prod > 21'(NUM_CAP)) ? NUM_CAP : mag_prod[MAG_W-1:0];
					end else begin
						nstage_n = NS_DONE;
					end
				end
				default: begin
					nstage_n = nstage_q;
				end
			endcase
		end
	end

	// line summary, taken from the state after this byte
	always_comb begin
		err_w   = (phase_n == PH_PREFIX);
		code_w  = CODE_NONE;
		num_w   = '0;
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			if (hits_n[k] && cmdlen_n == KW_LEN[k]) begin
				code_w = CODE_W'(k + 1);
			end
		end
		if (code_w == CODE_NONE && mag_n != '0) begin
			code_w = CODE_NUMERIC;
			num_w  = neg_n ? (NUM_W'(0) - NUM_W'(mag_n)) : NUM_W'(mag_n);
		end
		cnt_ext = 8'(pf_n) + 8'(phase_n == PH_PSTART);
		cnt_w   = (cnt_ext > 8'(CNT_MAX)) ? CNT_MAX : cnt_ext[CNT_W-1:0];
		if (err_w) begin
			code_w = CODE_NONE;
			num_w  = '0;
			cnt_w  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			off_q       <= '0;
			hits_q      <= '1;
			cmdlen_q    <= '0;
			mag_q       <= '0;
			neg_q       <= 1'b0;
			nstage_q    <= NS_SKIP;
			pf_q        <= '0;
			trail_q     <= 1'b0;
			bang_seen_q <= 1'b0;
			at_seen_q   <= 1'b0;
			bang_off_q  <= '0;
			at_off_q    <= '0;
			out_valid_q <= 1'b0;
			role_q      <= ROLE_DELIM;
			idx_q       <= '0;
			pos_q       <= '0;
			done_q      <= 1'b0;
			err_q       <= 1'b0;
			code_q      <= CODE_NONE;
			num_q       <= '0;
			cnt_q       <= '0;
			has_trail_q <= 1'b0;
			user_q      <= 1'b0;
			nick_end_q  <= '0;
			user_end_q  <= '0;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
				role_q      <= role_w;
				idx_q       <= idx_w;
				pos_q       <= pos_w;
				done_q      <= s_tlast;
				if (s_tlast) begin
					err_q       <= err_w;
					code_q      <= code_w;
					num_q       <= num_w;
					cnt_q       <= cnt_w;
					has_trail_q <= trail_n && !err_w;
					user_q      <= bang_seen_n && at_seen_n;
					nick_end_q  <= (bang_seen_n && at_seen_n) ? bang_off_n : '0;
					user_end_q  <= (bang_seen_n && at_seen_n) ? at_off_n : '0;
					// back to line start
					phase_q     <= PH_START;
					off_q       <= '0;
					hits_q      <= '1;
					cmdlen_q    <= '0;
					mag_q       <= '0;
					neg_q       <= 1'b0;
					nstage_q    <= NS_SKIP;
					pf_q        <= '0;
					trail_q     <= 1'b0;
					bang_seen_q <= 1'b0;
					at_seen_q   <= 1'b0;
					bang_off_q  <= '0;
					at_off_q    <= '0;
				end else begin
					err_q       <= 1'b0;
					code_q      <= CODE_NONE;
					num_q       <= '0;
					cnt_q       <= '0;
					has_trail_q <= 1'b0;
					user_q      <= 1'b0;
					nick_end_q  <= '0;
					user_end_q  <= '0;
					phase_q     <= phase_n;
					off_q       <= off_n;
					hits_q      <= hits_n;
					cmdlen_q    <= cmdlen_n;
					mag_q       <= mag_n;
					neg_q       <= neg_n;
					nstage_q    <= nstage_n;
					pf_q        <= pf_n;
					trail_q     <= trail_n;
					bang_seen_q <= bang_seen_n;
					at_seen_q   <= at_seen_n;
					bang_off_q  <= bang_off_n;
					at_off_q    <= at_off_n;
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = role_q;
	assign m_tlast  = done_q;
	assign m_tdata  = TDATA_W'({user_end_q, nick_end_q, user_q, has_trail_q, cnt_q,
		num_q, code_q, err_q, pos_q, idx_q});

	`IMLP_ASSERT_NOW(a_summary_zero, m_tvalid && !m_tlast, m_tdata[59:13] == '0,
		"summary fields set on a result that is not the last byte")
	`IMLP_ASSERT_NOW(a_error_clean, m_tvalid && err_q,
		code_q == CODE_NONE && cnt_q == '0 && !has_trail_q,
		"parse error reported with a command or parameters")
	`IMLP_ASSERT_NOW(a_numeric_nonzero, m_tvalid && code_q == CODE_NUMERIC, num_q != '0,
		"numeric command code with zero value")
	`IMLP_ASSERT_NEXT(a_line_restart, accept && s_tlast,
		phase_q == PH_START && off_q == '0 && pf_q == '0,
		"parser did not return to line start after the last byte")
	`IMLP_ASSERT_NOW(a_stall_blocks, m_tvalid && !m_tready, !s_tready,
		"input taken while a result is stalled")

endmodule

`default_nettype wire
